// ===== sv/lfd_pkg.sv =====
// lfd_pkg: shared types and constants for the length-framed packet deframer
// no dependencies; imported by lfd_frame_tracker and the core top level

package lfd_pkg;

    // frame position codes, 9 bits to cover the longest skip count
    localparam logic [8:0] POS_EXPECT_START  = 9'd0;
    localparam logic [8:0] POS_EXPECT_LENGTH = 9'd1;
    localparam logic [8:0] POS_FIRST_PAYLOAD = 9'd2;
    // offset from the length byte to the resync check byte while hunting
    localparam logic [8:0] SKIP_CHECK_OFFSET = 9'd3;

    // one result word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] byte_position;
        logic [7:0] frame_length;
        logic       last_of_packet;
        logic       empty_packet;
    } lfd_result_t;

    // result handed from the frame tracker to the output buffer
    typedef struct packed {
        logic        valid;
        lfd_result_t data;
    } lfd_result_msg_t;

endpackage

// ===== sv/lfd_ifs.sv =====
// lfd_ifs: valid/ready channel interfaces for the deframer
// no dependencies; used by the core top level

// received byte channel
interface lfd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// start byte register write channel
interface lfd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] start_byte;

    modport source (output valid, output start_byte, input ready);
    modport sink   (input valid, input start_byte, output ready);
endinterface

// deframed payload channel
interface lfd_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [7:0] byte_position;
    logic [7:0] frame_length;
    logic       last_of_packet;
    logic       empty_packet;

    modport source (output valid, output payload_byte, output byte_position,
                    output frame_length, output last_of_packet,
                    output empty_packet, input ready);
    modport sink   (input valid, input payload_byte, input byte_position,
                    input frame_length, input last_of_packet,
                    input empty_packet, output ready);
endinterface

// ===== sv/lfd_frame_tracker.sv =====
// lfd_frame_tracker: lock / hunt state and per-byte result for the deframer
// depends on lfd_pkg

module lfd_frame_tracker
    import lfd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [7:0]      rx_byte,
    input  logic [7:0]      start_byte,
    output lfd_result_msg_t result
);

    logic       locked_reg;
    logic       locked_next;
    logic [8:0] pos_reg;
    logic [8:0] pos_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;

    logic       is_start;
    logic [8:0] pos_inc;
    logic [8:0] payload_idx;
    logic       payload_last;
    logic       skip_done;

    // shared datapath terms
    assign is_start     = (rx_byte == start_byte);
    assign pos_inc      = pos_reg + 9'd1;
    assign payload_idx  = pos_reg - POS_FIRST_PAYLOAD;
    assign payload_last = ((pos_reg - 9'd1) >= {1'b0, len_reg});
    assign skip_done    = (pos_inc >= ({1'b0, len_reg} + SKIP_CHECK_OFFSET));

    // next state and result for one accepted word
    always_comb
    begin
        locked_next  = locked_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        result.valid = 1'b0;
        result.data  = '0;
        if (accept)
        begin
            if (locked_reg)
            begin
                priority if (pos_reg == POS_EXPECT_START)
                begin
                    if (is_start)
                    begin
                        pos_next = POS_EXPECT_LENGTH;
                    end
                    else
                    begin
                        locked_next = 1'b0;
                        pos_next    = POS_EXPECT_START;
                    end
                end
                else if (pos_reg == POS_EXPECT_LENGTH)
                begin
                    len_next = rx_byte;
                    if (rx_byte == 8'd0)
                    begin
                        // empty packet marker
                        result.valid               = 1'b1;
                        result.data.last_of_packet = 1'b1;
                        result.data.empty_packet   = 1'b1;
                        pos_next                   = POS_EXPECT_START;
                    end
                    else
                    begin
                        pos_next = POS_FIRST_PAYLOAD;
                    end
                end
                else
                begin
                    // payload word
                    result.valid               = 1'b1;
                    result.data.payload_byte   = rx_byte;
                    result.data.byte_position  = payload_idx[7:0];
                    result.data.frame_length   = len_reg;
                    result.data.last_of_packet = payload_last;
                    pos_next = payload_last ? POS_EXPECT_START : pos_inc;
                end
            end
            else
            begin
                priority if (pos_reg == POS_EXPECT_START)
                begin
                    if (is_start)
                    begin
                        pos_next = POS_EXPECT_LENGTH;
                    end
                end
                else if (pos_reg == POS_EXPECT_LENGTH)
                begin
                    len_next = rx_byte;
                    pos_next = POS_FIRST_PAYLOAD;
                end
                else
                begin
                    // skip one frame, then check for the next start byte
                    pos_next = pos_inc;
                    if (skip_done)
                    begin
                        if (is_start)
                        begin
                            locked_next = 1'b1;
                            pos_next    = POS_EXPECT_LENGTH;
                        end
                        else
                        begin
                            pos_next = POS_EXPECT_START;
                        end
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg <= 1'b0;
            pos_reg    <= POS_EXPECT_START;
            len_reg    <= 8'd0;
        end
        else
        begin
            locked_reg <= locked_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
        end
    end

endmodule

// ===== sv/length_framed_packet_deframer_core.sv =====
// length_framed_packet_deframer_core: top level, start byte register and output buffer
// depends on lfd_pkg, lfd_ifs and lfd_frame_tracker
//
//   channel   dir   payload                                   handshake
//   rx_chan   in    rx_byte                                   valid/ready
//   cfg_chan  in    start_byte                                valid/ready (always ready)
//   tx_chan   out   payload_byte, byte_position, frame_length,
//                   last_of_packet, empty_packet              valid/ready
//
// one received word per cycle while rx_chan.ready is high; its result is registered.
// a two-entry output buffer (output register plus skid) lets input flow while one
// result waits; rx_chan.ready drops only when both entries are full.
// asynchronous active-low reset clears lock state, start byte and buffer valids.

module length_framed_packet_deframer_core
    import lfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lfd_rx_if.sink   rx_chan,
    lfd_cfg_if.sink  cfg_chan,
    lfd_tx_if.source tx_chan
);

    logic [7:0]      start_val_reg;
    logic            rx_accept;
    logic            tx_pop;
    lfd_result_msg_t result;

    logic            out_valid_reg;
    logic            out_valid_next;
    lfd_result_t     out_data_reg;
    lfd_result_t     out_data_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    lfd_result_t     skid_data_reg;
    lfd_result_t     skid_data_next;

    // start byte register
    assign cfg_chan.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_val_reg <= 8'd0;
        end
        else if (cfg_chan.valid)
        begin
            start_val_reg <= cfg_chan.start_byte;
        end
    end

    // handshakes
    assign rx_chan.ready = !skid_valid_reg;
    assign rx_accept     = rx_chan.valid && !skid_valid_reg;
    assign tx_pop        = out_valid_reg && tx_chan.ready;

    lfd_frame_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (rx_accept),
        .rx_byte    (rx_chan.rx_byte),
        .start_byte (start_val_reg),
        .result     (result)
    );

    // output register and skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (tx_pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (result.valid)
        begin
            if (!out_valid_reg || tx_pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result.data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result.data;
            end
        end
        else if (tx_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // result port
    assign tx_chan.valid          = out_valid_reg;
    assign tx_chan.payload_byte   = out_data_reg.payload_byte;
    assign tx_chan.byte_position  = out_data_reg.byte_position;
    assign tx_chan.frame_length   = out_data_reg.frame_length;
    assign tx_chan.last_of_packet = out_data_reg.last_of_packet;
    assign tx_chan.empty_packet   = out_data_reg.empty_packet;

endmodule

// ===== tb/tb_length_framed_packet_deframer_core.sv =====
// tb_length_framed_packet_deframer_core: self-checking testbench for the packet deframer core
// depends on lfd_pkg, lfd_ifs and length_framed_packet_deframer_core
// predicts every output word from the received words and checks them in order

`timescale 1ns / 100ps

module tb_length_framed_packet_deframer_core;

    import lfd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_HOLD     = 40;
    localparam int DRAIN_LIMIT   = 2000;

    logic clk;
    logic rst_n;

    lfd_rx_if  rx_chan ();
    lfd_cfg_if cfg_chan ();
    lfd_tx_if  tx_chan ();

    length_framed_packet_deframer_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_chan  (rx_chan),
        .cfg_chan (cfg_chan),
        .tx_chan  (tx_chan)
    );

    // deframer state as the testbench tracks it
    logic        trk_locked;
    logic [8:0]  trk_pos;
    logic [7:0]  trk_len;
    logic [7:0]  start_code;

    // words still owed by the block, oldest first
    lfd_result_t expected_words[$];

    // run bookkeeping
    int  mismatches;
    int  cycle_count;
    int  bytes_sent;
    int  frames_sent;
    int  config_writes;
    int  words_checked;
    int  empty_seen;
    int  rx_stall_cycles;

    // idling controls
    bit  send_gaps_on;
    bit  sink_stalls_on;
    int  hold_requests;
    int  hold_served;
    int  sink_wait;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // expected output of one received word, updates the tracked state
    function automatic void deframe_step(input logic [7:0] b);
        lfd_result_t word;
        logic [8:0]  idx;
        logic        done;
        word = '0;
        if (trk_locked)
        begin
            if (trk_pos == POS_EXPECT_START)
            begin
                if (b == start_code)
                    trk_pos = POS_EXPECT_LENGTH;
                else
                begin
                    // start byte mismatch drops lock
                    trk_locked = 1'b0;
                    trk_pos    = POS_EXPECT_START;
                end
            end
            else if (trk_pos == POS_EXPECT_LENGTH)
            begin
                trk_len = b;
                if (b == 8'd0)
                begin
                    // zero-length frame gives one empty marker
                    word.last_of_packet = 1'b1;
                    word.empty_packet   = 1'b1;
                    expected_words.push_back(word);
                    trk_pos = POS_EXPECT_START;
                end
                else
                    trk_pos = POS_FIRST_PAYLOAD;
            end
            else
            begin
                idx  = trk_pos - POS_FIRST_PAYLOAD;
                done = (int'(idx) + 1 >= int'(trk_len));
                word.payload_byte   = b;
                word.byte_position  = idx[7:0];
                word.frame_length   = trk_len;
                word.last_of_packet = done;
                expected_words.push_back(word);
                if (done)
                    trk_pos = POS_EXPECT_START;
                else
                    trk_pos = trk_pos + 9'd1;
            end
        end
        else
        begin
            // hunting: find start byte, skip a frame, check the next byte
            if (trk_pos == POS_EXPECT_START)
            begin
                if (b == start_code)
                    trk_pos = POS_EXPECT_LENGTH;
            end
            else if (trk_pos == POS_EXPECT_LENGTH)
            begin
                trk_len = b;
                trk_pos = POS_FIRST_PAYLOAD;
            end
            else
            begin
                trk_pos = trk_pos + 9'd1;
                if (int'(trk_pos) >= int'(trk_len) + int'(SKIP_CHECK_OFFSET))
                begin
                    if (b == start_code)
                    begin
                        trk_locked = 1'b1;
                        trk_pos    = POS_EXPECT_LENGTH;
                    end
                    else
                        trk_pos = POS_EXPECT_START;
                end
            end
        end
    endfunction

    function automatic void check_field(input string fname, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%02h, got 0x%02h", fname, want, got);
            mismatches++;
        end
    endfunction

    // output sink with random stalls and requested long holds
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            sink_wait   = LONG_HOLD;
        end
        if (sink_wait > 0)
        begin
            tx_chan.ready <= 1'b0;
            sink_wait--;
        end
        else if (sink_stalls_on && $urandom_range(0, 5) == 0)
        begin
            tx_chan.ready <= 1'b0;
            sink_wait = $urandom_range(0, 3);
        end
        else
            tx_chan.ready <= 1'b1;
    end

    // output word checker, stall monitor and timeout
    always @(posedge clk)
    begin : word_check
        lfd_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            if (rst_n && rx_chan.valid && !rx_chan.ready)
                rx_stall_cycles++;
            if (rst_n && tx_chan.valid && tx_chan.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: payload 0x%02h position %0d length %0d",
                           tx_chan.payload_byte, tx_chan.byte_position,
                           tx_chan.frame_length);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("payload_byte", want.payload_byte, tx_chan.payload_byte);
                    check_field("byte_position", want.byte_position, tx_chan.byte_position);
                    check_field("frame_length", want.frame_length, tx_chan.frame_length);
                    check_field("last_of_packet", {7'd0, want.last_of_packet},
                                {7'd0, tx_chan.last_of_packet});
                    check_field("empty_packet", {7'd0, want.empty_packet},
                                {7'd0, tx_chan.empty_packet});
                    words_checked++;
                    if (want.empty_packet)
                        empty_seen++;
                end
            end
        end
    end

    // send one received word, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        if (send_gaps_on && $urandom_range(0, 4) == 0)
        begin
            rx_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.rx_byte <= b;
        @(posedge clk);
        while (!rx_chan.ready)
            @(posedge clk);
        deframe_step(b);
        bytes_sent++;
    endtask

    // payload content, biased toward the start byte to tempt false locks
    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 7) == 0)
            return start_code;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 0;
        if (r < 70)
            return $urandom_range(1, 8);
        if (r < 97)
            return $urandom_range(9, 40);
        return $urandom_range(41, 120);
    endfunction

    task automatic send_frame(input logic [7:0] lead, input int len);
        send_byte(lead);
        send_byte(8'(len));
        repeat (len) send_byte(pick_payload());
        frames_sent++;
    endtask

    // stop sending and let every owed word come out
    task automatic wait_idle();
        rx_chan.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_start(input logic [7:0] code);
        cfg_chan.valid      <= 1'b1;
        cfg_chan.start_byte <= code;
        @(posedge clk);
        while (!cfg_chan.ready)
            @(posedge clk);
        cfg_chan.valid <= 1'b0;
        start_code = code;
        config_writes++;
    endtask

    // start byte of zero after reset, lock gained by skipping one frame
    task automatic test_reset_start_byte();
        send_frame(8'h00, 2);
        send_frame(8'h00, 3);
        send_frame(8'h00, 0);
    endtask

    // field extremes, empty marker, lock loss, failed and good resync
    task automatic test_directed_frames();
        wait_idle();
        write_start(8'hA5);
        send_byte(8'hA5);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h00);
        // wrong start byte while locked
        send_byte(8'h5A);
        // hunt, skip two bytes, check byte is not the start byte
        send_byte(8'hA5);
        send_byte(8'h02);
        send_byte(8'h33);
        send_byte(8'hCC);
        send_byte(8'h11);
        // hunt over an empty frame, then relock
        send_byte(8'hA5);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // start byte changed between words of a frame
    task automatic test_register_midframe();
        wait_idle();
        write_start(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h04);
        send_byte(8'h12);
        send_byte(8'hFF);
        wait_idle();
        write_start(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_frame(8'h00, 1);
        // same while hunting
        send_byte(8'h77);
        send_byte(8'h00);
        send_byte(8'h03);
        send_byte(8'h3C);
        wait_idle();
        write_start(8'h3C);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h3C);
        send_byte(8'h01);
        send_byte(8'h7E);
    endtask

    // longest frame while locked and while hunting
    task automatic test_longest_frame();
        send_frame(start_code, 255);
        send_byte(~start_code);
        send_frame(start_code, 255);
        send_frame(start_code, 2);
    endtask

    // sink holds off long enough for the input to stall
    task automatic test_output_backpressure();
        bit saved_gaps;
        saved_gaps   = send_gaps_on;
        send_gaps_on = 1'b0;
        hold_requests++;
        send_frame(start_code, 30);
        send_gaps_on = saved_gaps;
    endtask

    // sender stops until everything owed has come out
    task automatic test_sender_pause();
        send_frame(start_code, 5);
        send_frame(start_code, 0);
        wait_idle();
        repeat (20) @(posedge clk);
        send_frame(start_code, 3);
    endtask

    // mostly well-formed frames, some noise, truncation and bad leads
    task automatic run_random_phase(input int target);
        int framed;
        int kind;
        int len;
        framed = 0;
        while (framed < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 78)
            begin
                len = pick_len();
                send_frame(start_code, len);
                framed += len + 2;
            end
            else if (kind < 86)
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            else if (kind < 93)
            begin
                len = pick_len() + 1;
                send_byte(start_code);
                send_byte(8'(len));
                repeat ($urandom_range(0, len - 1)) send_byte(pick_payload());
                framed += 2;
            end
            else
            begin
                len = pick_len();
                send_frame(start_code ^ 8'($urandom_range(1, 255)), len);
                framed += len + 2;
            end
        end
    endtask

    task automatic test_random_traffic();
        logic [7:0] codes[4];
        codes[0] = 8'($urandom_range(1, 254));
        codes[1] = 8'h00;
        codes[2] = 8'hFF;
        codes[3] = 8'($urandom_range(0, 255));
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            // last stretch runs without idling on either side
            if (ph == 3)
            begin
                send_gaps_on   = 1'b0;
                sink_stalls_on = 1'b0;
            end
            write_start(codes[ph]);
            run_random_phase(30);
        end
    endtask

    initial
    begin
        int waited;
        clk                 = 1'b0;
        rst_n               = 1'b0;
        rx_chan.valid       = 1'b0;
        rx_chan.rx_byte     = 8'h00;
        cfg_chan.valid      = 1'b0;
        cfg_chan.start_byte = 8'h00;
        tx_chan.ready       = 1'b0;
        trk_locked          = 1'b0;
        trk_pos             = POS_EXPECT_START;
        trk_len             = 8'h00;
        start_code          = 8'h00;
        send_gaps_on        = 1'b1;
        sink_stalls_on      = 1'b1;
        hold_requests       = 0;
        hold_served         = 0;
        sink_wait           = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_start_byte();
        test_directed_frames();
        test_register_midframe();
        test_longest_frame();
        test_output_backpressure();
        test_sender_pause();
        test_random_traffic();

        // drain with a bound, then let the pipeline settle
        rx_chan.valid <= 1'b0;
        waited = 0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            $error("%0d expected words never arrived", expected_words.size());
            mismatches++;
        end

        $display("Covered %0d received words in %0d frames over %0d start byte settings",
                 bytes_sent, frames_sent, config_writes);
        $display("Checked %0d output words (%0d empty markers), input stalled %0d cycles",
                 words_checked, empty_seen, rx_stall_cycles);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lfd_pkg.sv
sv/lfd_ifs.sv
sv/lfd_frame_tracker.sv
sv/length_framed_packet_deframer_core.sv
tb/tb_length_framed_packet_deframer_core.sv
